[design/ble_pkg.sv]
// Shared types and constants for the box list pixel erase block.
`default_nettype none
package ble_pkg;

  localparam int MAX_BOXES   = 16;
  localparam int MAX_DIM     = 8192;
  localparam int SAMPLE_BITS = 32;

  // fixed field widths
  localparam int EDGE_W  = 13;
  localparam int SLOT_W  = 4;
  localparam int RDIM_W  = 14;
  localparam int COUNT_W = 5;
  localparam int PORT_W  = 32;

  // column and row counters
  localparam int CNT_W    = $clog2(MAX_DIM);
  localparam int DIM_CMP_W = ((CNT_W + 1) > RDIM_W) ? (CNT_W + 1) : RDIM_W;
  // image coordinates: counter plus region origin
  localparam int POS_W    = ((CNT_W > EDGE_W) ? CNT_W : EDGE_W) + 1;

  // cell index, wide enough to hold MAX_BOXES itself
  localparam int IDX_W    = $clog2(MAX_BOXES + 1);
  localparam int IDX_CMP_W = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;
  localparam int SLOT_CMP_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_TOP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_COUNT     = 3'd4;

  // action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_PIXEL = 1'b1;

  // transaction payload handed from cell to cell
  typedef struct packed {
    logic                   pixel;
    logic [SLOT_W-1:0]      slot;
    logic [EDGE_W-1:0]      left;
    logic [EDGE_W-1:0]      top;
    logic [EDGE_W-1:0]      right;
    logic [EDGE_W-1:0]      bottom;
    logic [POS_W-1:0]       x;
    logic [POS_W-1:0]       y;
    logic [SAMPLE_BITS-1:0] a;
    logic [SAMPLE_BITS-1:0] b;
    logic [SAMPLE_BITS-1:0] c;
    logic                   hit;
    logic                   row_end;
    logic                   frame_end;
  } token_t;

endpackage
`default_nettype wire

[design/ble_cell.sv]
// One cell of the box chain: holds one box, loads it or tests a passing pixel.
`default_nettype none
module ble_cell import ble_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               advance,
  input  wire logic [IDX_W-1:0]   index,
  input  wire logic [COUNT_W-1:0] box_count,
  input  wire logic               prev_valid,
  input  wire token_t             prev,
  output logic                    valid,
  output token_t                  token
);

  logic [EDGE_W-1:0]      left;
  logic [EDGE_W-1:0]      top;
  logic [EDGE_W-1:0]      right;
  logic [EDGE_W-1:0]      bottom;
  logic [SAMPLE_BITS-1:0] color_a;
  logic [SAMPLE_BITS-1:0] color_b;
  logic [SAMPLE_BITS-1:0] color_c;

  logic   load_here;
  logic   in_use;
  logic   inside_box;
  token_t token_next;

  assign load_here = prev_valid && !prev.pixel &&
                     (SLOT_CMP_W'(prev.slot) == SLOT_CMP_W'(index));
  assign in_use    = IDX_CMP_W'(index) < IDX_CMP_W'(box_count);
  assign inside_box = (prev.x >= POS_W'(left))  && (prev.x <= POS_W'(right)) &&
                      (prev.y >= POS_W'(top))   && (prev.y <= POS_W'(bottom));

  always_comb begin
    token_next = prev;
    // first box in list order wins: skip once hit
    if (prev.pixel && !prev.hit && in_use && inside_box) begin
      token_next.a   = color_a;
      token_next.b   = color_b;
      token_next.c   = color_c;
      token_next.hit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load_here) begin
      left    <= prev.left;
      top     <= prev.top;
      right   <= prev.right;
      bottom  <= prev.bottom;
      color_a <= prev.a;
      color_b <= prev.b;
      color_c <= prev.c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      token <= token_next;
    end
  end

endmodule
`default_nettype wire

[design/box_list_pixel_erase.sv]
// Top level of the box list pixel erase block: scan counters, registers, cell chain.
//
//   channel  direction  handshake              payload
//   pix      in         pix_valid / pix_stall  action, box_slot, box edges, value_a..c
//   res      out        res_valid / res_stall  out_a..c, erased, row_end, frame_end
//   cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Unless held, one transaction per cycle enters the MAX_BOXES cells; each holds one box.
// A pixel result leaves the chain after every cell's register; a load gives none.
// Loads move like pixels; each pixel sees boxes loaded before it in slots below box_count.
// The whole chain holds while a result waits under res_stall; pix_stall follows it.
// Reset clears counters, registers (width and height to MAX_DIM), valid bits; boxes stay.
`default_nettype none
module box_list_pixel_erase import ble_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 pix_valid,
  output logic                      pix_stall,
  input  wire logic                 action,
  input  wire logic [SLOT_W-1:0]    box_slot,
  input  wire logic [EDGE_W-1:0]    box_left,
  input  wire logic [EDGE_W-1:0]    box_top,
  input  wire logic [EDGE_W-1:0]    box_right,
  input  wire logic [EDGE_W-1:0]    box_bottom,
  input  wire logic [PORT_W-1:0]    value_a,
  input  wire logic [PORT_W-1:0]    value_b,
  input  wire logic [PORT_W-1:0]    value_c,
  output logic                      res_valid,
  input  wire logic                 res_stall,
  output logic [PORT_W-1:0]         out_a,
  output logic [PORT_W-1:0]         out_b,
  output logic [PORT_W-1:0]         out_c,
  output logic                      erased,
  output logic                      row_end,
  output logic                      frame_end,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [RDIM_W-1:0]    cfg_data
);

  logic [EDGE_W-1:0]  region_left;
  logic [EDGE_W-1:0]  region_top;
  logic [RDIM_W-1:0]  region_width;
  logic [RDIM_W-1:0]  region_height;
  logic [COUNT_W-1:0] box_count;

  logic [CNT_W-1:0] column_count;
  logic [CNT_W-1:0] row_count;

  logic [DIM_CMP_W-1:0] width_clamped;
  logic [DIM_CMP_W-1:0] height_clamped;
  logic                 last_col;
  logic                 last_row;
  logic                 advance;
  logic                 accept;
  token_t               entry;

  logic   chain_valid [MAX_BOXES+1];
  token_t chain       [MAX_BOXES+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_left   <= '0;
      region_top    <= '0;
      region_width  <= RDIM_W'(MAX_DIM);
      region_height <= RDIM_W'(MAX_DIM);
      box_count     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_REGION_LEFT:   region_left   <= cfg_data[EDGE_W-1:0];
        REG_REGION_TOP:    region_top    <= cfg_data[EDGE_W-1:0];
        REG_REGION_WIDTH:  region_width  <= cfg_data;
        REG_REGION_HEIGHT: region_height <= cfg_data;
        REG_BOX_COUNT:     box_count     <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (region_width == '0) begin
      width_clamped = DIM_CMP_W'(1);
    end else if (DIM_CMP_W'(region_width) > DIM_CMP_W'(MAX_DIM)) begin
      width_clamped = DIM_CMP_W'(MAX_DIM);
    end else begin
      width_clamped = DIM_CMP_W'(region_width);
    end
    if (region_height == '0) begin
      height_clamped = DIM_CMP_W'(1);
    end else if (DIM_CMP_W'(region_height) > DIM_CMP_W'(MAX_DIM)) begin
      height_clamped = DIM_CMP_W'(MAX_DIM);
    end else begin
      height_clamped = DIM_CMP_W'(region_height);
    end
  end

  // a counter at or beyond the last position counts as the last one
  assign last_col = DIM_CMP_W'(column_count) >= (width_clamped - DIM_CMP_W'(1));
  assign last_row = DIM_CMP_W'(row_count) >= (height_clamped - DIM_CMP_W'(1));

  // hold the chain only while a pixel result sits unaccepted at its end
  assign advance   = !(chain_valid[MAX_BOXES] && chain[MAX_BOXES].pixel && res_stall);
  assign pix_stall = !advance;
  assign accept    = pix_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept && (action == ACT_PIXEL)) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + CNT_W'(1);
      end else begin
        column_count <= column_count + CNT_W'(1);
      end
    end
  end

  always_comb begin
    entry.pixel     = (action == ACT_PIXEL);
    entry.slot      = box_slot;
    entry.left      = box_left;
    entry.top       = box_top;
    entry.right     = box_right;
    entry.bottom    = box_bottom;
    entry.x         = POS_W'(column_count) + POS_W'(region_left);
    entry.y         = POS_W'(row_count) + POS_W'(region_top);
    entry.a         = value_a[SAMPLE_BITS-1:0];
    entry.b         = value_b[SAMPLE_BITS-1:0];
    entry.c         = value_c[SAMPLE_BITS-1:0];
    entry.hit       = 1'b0;
    entry.row_end   = last_col;
    entry.frame_end = last_col && last_row;
  end

  assign chain_valid[0] = pix_valid;
  assign chain[0]       = entry;

  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
    ble_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .advance    (advance),
      .index      (IDX_W'(i)),
      .box_count  (box_count),
      .prev_valid (chain_valid[i]),
      .prev       (chain[i]),
      .valid      (chain_valid[i+1]),
      .token      (chain[i+1])
    );
  end

  // loads drop off the end of the chain
  assign res_valid = chain_valid[MAX_BOXES] && chain[MAX_BOXES].pixel;
  assign out_a     = PORT_W'(chain[MAX_BOXES].a);
  assign out_b     = PORT_W'(chain[MAX_BOXES].b);
  assign out_c     = PORT_W'(chain[MAX_BOXES].c);
  assign erased    = chain[MAX_BOXES].hit;
  assign row_end   = chain[MAX_BOXES].row_end;
  assign frame_end = chain[MAX_BOXES].frame_end;

endmodule
`default_nettype wire
